[design/grid_motion_chain_detect_core_macros.svh]
// Assertion macros shared by the grid motion chain detector.
`ifndef GRID_MOTION_CHAIN_DETECT_CORE_MACROS_SVH
`define GRID_MOTION_CHAIN_DETECT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GMCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GMCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/gmcd_pkg.sv]
// Types, codes and a helper function of the grid motion chain detector.
package gmcd_pkg;

	localparam int FIELD_LIMIT = 8;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_SCAN  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_ACTIVE_COLS = 2'd0;
	localparam logic [1:0] REG_ACTIVE_ROWS = 2'd1;
	localparam logic [1:0] REG_CHAIN_LEN   = 2'd2;
	localparam logic [1:0] REG_USEFUL_TIME = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  cell_row;
		logic [2:0]  cell_col;
		logic [31:0] stamp;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0] row;
		logic [7:0] right_starts;
		logic [7:0] left_starts;
		logic       last;
	} row_result_t;

	// Outcome of one gap check: later-minus-earlier in range, or the reverse.
	typedef struct packed {
		logic fwd_ok;
		logic rev_ok;
	} gap_flags_t;

	typedef struct packed {
		logic [7:0] right;
		logic [7:0] left;
	} mask_pair_t;

	// Turns per-column link flags of one row into start-column masks.
	// newest[c]: cell c is valid and fired within range of the scan time.
	// rlink[c]:  cells c and c+1 valid and c+1 fired after c within range.
	// llink[c]:  cells c and c+1 valid and c fired after c+1 within range.
	function automatic mask_pair_t build_masks(input logic [7:0] newest,
			input logic [7:0] rlink, input logic [7:0] llink,
			input logic [3:0] len, input logic [3:0] cols);
		mask_pair_t res;
		logic [7:0] run;
		logic [7:0] rsh;
		logic [7:0] lsh;
		logic [7:0] nsh;
		logic       fit;
		res = '0;
		run = 8'((16'd1 << (len - 4'd1)) - 16'd1);
		for (int x = 0; x < FIELD_LIMIT; x++) begin
			fit = ({2'b0, 3'(x)} + {1'b0, len}) <= {1'b0, cols};
			rsh = rlink >> x;
			lsh = llink >> x;
			nsh = newest >> (5'(x) + {1'b0, len} - 5'd1);
			res.right[x] = fit && nsh[0] && ((rsh & run) == run);
			nsh = newest >> x;
			res.left[x] = fit && nsh[0] && ((lsh & run) == run);
		end
		return res;
	endfunction

endpackage

[design/gmcd_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module gmcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/gmcd_gap.sv]
// Shared gap checker: tests a time difference in either direction against the limit.
module gmcd_gap (
	input  logic [31:0]        later,
	input  logic [31:0]        earlier,
	input  logic [15:0]        limit,
	output gmcd_pkg::gap_flags_t flags
);

	logic [31:0] fwd_diff;
	logic [31:0] rev_diff;
	logic        is_after;
	logic        is_before;

	assign fwd_diff  = later - earlier;
	assign rev_diff  = earlier - later;
	assign is_after  = later > earlier;
	assign is_before = later < earlier;

	assign flags.fwd_ok = is_after && (fwd_diff <= {16'd0, limit});
	assign flags.rev_ok = is_before && (rev_diff <= {16'd0, limit});

endmodule

[design/grid_motion_chain_detect_core.sv]
// Top level of the grid motion chain detector: command decode, scan sequencer and cell store.
//
//  channel   handshake                 payload
//  --------  ------------------------  -----------------------------------------
//  command   start, busy               item   (cmd, cell_row, cell_col, stamp)
//  result    result_strobe             result (row, right_starts, left_starts, last)
//  config    cfg_we                    cfg_index, cfg_data
//
// A write or clear item completes while busy stays low. A scan item walks each
// active row column by column: column zero costs a RAM read and a check against
// the scan time, every further column adds a check against its left neighbour,
// all through the one shared gap checker, and one emit step closes the row.
// A row's result is on the ports in the cycle after its emit step; last marks the
// final row, whose result appears as busy falls.
// Reset clears the control registers and the valid bits at once; no clearing pass runs.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module grid_motion_chain_detect_core #(
	parameter int MAX_COLS = 8,
	parameter int MAX_ROWS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  gmcd_pkg::cmd_item_t    item,
	output logic                   result_strobe,
	output gmcd_pkg::row_result_t  result,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);

`include "grid_motion_chain_detect_core_macros.svh"

	// Only the first eight rows and columns can ever be written or reported,
	// so the store holds no more than that.
	localparam int COLS_ST = (MAX_COLS > gmcd_pkg::FIELD_LIMIT) ? gmcd_pkg::FIELD_LIMIT : MAX_COLS;
	localparam int ROWS_ST = (MAX_ROWS > gmcd_pkg::FIELD_LIMIT) ? gmcd_pkg::FIELD_LIMIT : MAX_ROWS;
	localparam int DEPTH   = ROWS_ST * COLS_ST;
	localparam int AW      = $clog2(DEPTH);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_NEWEST = 5'b00100,
		S_PAIR   = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0]  active_cols_q;
	logic [3:0]  active_rows_q;
	logic [3:0]  chain_len_q;
	logic [15:0] useful_time_q;

	// Effective grid size after saturation.
	logic [3:0] cols_eff;
	logic [3:0] rows_eff;
	logic [2:0] last_col;

	// Scan context and per-row link flags.
	logic [31:0] stamp_q;
	logic [2:0]  row_q;
	logic [2:0]  col_q;
	logic        valid_s1;
	logic [31:0] cur_time_q;
	logic        cur_valid_q;
	logic [31:0] prev_time_q;
	logic        prev_valid_q;
	logic [7:0]  newest_q;
	logic [7:0]  rlink_q;
	logic [7:0]  llink_q;

	logic [DEPTH-1:0] valid_q;

	logic        accept;
	logic        do_write;
	logic        do_clear;
	logic        do_scan;
	logic [6:0]  waddr_full;
	logic [6:0]  raddr_full;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [31:0] rdata;

	logic [31:0]          gap_later;
	logic [31:0]          gap_earlier;
	gmcd_pkg::gap_flags_t gap_flags;
	gmcd_pkg::mask_pair_t masks;

	logic col_done;
	logic row_done;

	assign cols_eff = (active_cols_q > 4'(COLS_ST)) ? 4'(COLS_ST) : active_cols_q;
	assign rows_eff = (active_rows_q > 4'(ROWS_ST)) ? 4'(ROWS_ST) : active_rows_q;
	// With fewer than one active column the walk still visits column zero;
	// the masks come out empty because no chain fits.
	assign last_col = (cols_eff == 4'd0) ? 3'd0 : 3'(cols_eff - 4'd1);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign do_write = accept && (item.cmd == gmcd_pkg::CMD_WRITE)
		&& ({1'b0, item.cell_row} < 4'(ROWS_ST)) && ({1'b0, item.cell_col} < 4'(COLS_ST));
	assign do_clear = accept && (item.cmd == gmcd_pkg::CMD_CLEAR);
	// A scan with chains disabled or no active rows produces nothing at all.
	assign do_scan  = accept && (item.cmd == gmcd_pkg::CMD_SCAN)
		&& (chain_len_q != 4'd0) && (rows_eff != 4'd0);

	assign waddr_full = 7'(item.cell_row) * 7'(COLS_ST) + 7'(item.cell_col);
	assign raddr_full = 7'(row_q) * 7'(COLS_ST) + 7'(col_q);
	assign waddr      = waddr_full[AW-1:0];
	assign raddr      = raddr_full[AW-1:0];

	gmcd_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_time_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (waddr),
		.wdata (item.stamp),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The gap checker compares a cell against the scan time in the newest
	// step, and a cell against its left neighbour in the pair step.
	always_comb begin
		if (state_q == S_PAIR) begin
			gap_later   = cur_time_q;
			gap_earlier = prev_time_q;
		end else begin
			gap_later   = stamp_q;
			gap_earlier = rdata;
		end
	end

	gmcd_gap u_gap (
		.later   (gap_later),
		.earlier (gap_earlier),
		.limit   (useful_time_q),
		.flags   (gap_flags)
	);

	assign masks    = gmcd_pkg::build_masks(newest_q, rlink_q, llink_q, chain_len_q, cols_eff);
	assign col_done = (col_q == last_col);
	assign row_done = ({1'b0, row_q} == (rows_eff - 4'd1));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cols_q <= 4'd8;
			active_rows_q <= 4'd8;
			chain_len_q   <= 4'd3;
			useful_time_q <= 16'd500;
		end else if (cfg_we) begin
			case (cfg_index)
				gmcd_pkg::REG_ACTIVE_COLS: active_cols_q <= cfg_data[3:0];
				gmcd_pkg::REG_ACTIVE_ROWS: active_rows_q <= cfg_data[3:0];
				gmcd_pkg::REG_CHAIN_LEN:   chain_len_q   <= cfg_data[3:0];
				gmcd_pkg::REG_USEFUL_TIME: useful_time_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Valid bits: a clear wipes them all at once; stored times stay.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_clear) begin
			valid_q <= '0;
		end else if (do_write) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Scan sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			row_q         <= 3'd0;
			col_q         <= 3'd0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (do_scan) begin
						row_q   <= 3'd0;
						col_q   <= 3'd0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_NEWEST;
				end
				S_NEWEST: begin
					if (col_q != 3'd0) begin
						state_q <= S_PAIR;
					end else if (col_done) begin
						state_q <= S_EMIT;
					end else begin
						col_q   <= col_q + 3'd1;
						state_q <= S_READ;
					end
				end
				S_PAIR: begin
					if (col_done) begin
						state_q <= S_EMIT;
					end else begin
						col_q   <= col_q + 3'd1;
						state_q <= S_READ;
					end
				end
				S_EMIT: begin
					result_strobe <= 1'b1;
					col_q         <= 3'd0;
					if (row_done) begin
						state_q <= S_IDLE;
					end else begin
						row_q   <= row_q + 3'd1;
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan datapath; payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (do_scan) begin
			stamp_q <= item.stamp;
		end
		if (state_q == S_READ) begin
			valid_s1 <= valid_q[raddr];
		end
		if (state_q == S_NEWEST) begin
			newest_q[col_q] <= valid_s1 && gap_flags.fwd_ok;
			cur_time_q      <= rdata;
			cur_valid_q     <= valid_s1;
			if (col_q == 3'd0) begin
				prev_time_q  <= rdata;
				prev_valid_q <= valid_s1;
			end
		end
		if (state_q == S_PAIR) begin
			rlink_q[col_q - 3'd1] <= cur_valid_q && prev_valid_q && gap_flags.fwd_ok;
			llink_q[col_q - 3'd1] <= cur_valid_q && prev_valid_q && gap_flags.rev_ok;
			prev_time_q           <= cur_time_q;
			prev_valid_q          <= cur_valid_q;
		end
		if (state_q == S_EMIT) begin
			result.row          <= row_q;
			result.right_starts <= masks.right;
			result.left_starts  <= masks.left;
			result.last         <= row_done;
		end
	end

	// The final row result of a scan leaves as the sequencer falls idle.
	`GMCD_ASSERT_NOW(a_last_idle, clk, arst_n, result_strobe && result.last, !busy,
		"last result while the sequencer is still busy")

	// A scan that has work to do always engages the sequencer.
	`GMCD_ASSERT_NEXT(a_scan_engages, clk, arst_n, do_scan, busy,
		"accepted scan did not start the sequencer")

	// Writes and clears complete without raising busy or a result strobe.
	`GMCD_ASSERT_NEXT(a_single_cycle, clk, arst_n, accept && (item.cmd != gmcd_pkg::CMD_SCAN),
		!busy && !result_strobe, "write or clear item kept the block busy")

	// Reported rows stay within the active row count.
	`GMCD_ASSERT_NOW(a_row_range, clk, arst_n, result_strobe,
		{1'b0, result.row} < rows_eff, "result row beyond the active rows")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the grid motion chain detector against a row mask predictor.
module testbench;

	// The block ignores the fourth command code; it is sent as noise.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Grid geometry of the instance, which keeps the default parameters.
	localparam int GRID_COLS = 8;
	localparam int GRID_ROWS = 8;
	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;

	// The longest scan walks eight rows of eight columns. Before a register write
	// we wait at least as long as that scan and until busy falls, so that no scan
	// is in flight when a register changes.
	localparam int SETTLE_CYCLES = 3 * GRID_COLS * GRID_ROWS + 8;

	// Several times the slowest correct run: every item a full eight row scan,
	// plus the sender gaps and the settling pauses between register settings.
	localparam int CYCLE_LIMIT = 500000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	gmcd_pkg::cmd_item_t   item;
	logic                  result_strobe;
	gmcd_pkg::row_result_t result;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [15:0]           cfg_data;

	grid_motion_chain_detect_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predictor copy of the cell store and of the registers.
	logic [31:0]  cell_stamp [GRID_CELLS];
	logic         cell_live [GRID_CELLS];
	logic [3:0]   cfg_cols;
	logic [3:0]   cfg_rows;
	logic [3:0]   cfg_len;
	logic [15:0]  cfg_window;

	// Row results that the block still owes, oldest first.
	gmcd_pkg::row_result_t pending_rows [$];
	gmcd_pkg::row_result_t oldest_row;

	int           error_count = 0;
	int           items_sent = 0;
	int           cycle_count = 0;
	int           sender_idle_pct = 31;

	// Running notion of the current time, so that chains and scans line up.
	logic [31:0]  now_ticks;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a run that hangs must still end with a verdict.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void reset_predictor();
		cfg_cols = 4'd8;
		cfg_rows = 4'd8;
		cfg_len = 4'd3;
		cfg_window = 16'd500;
		for (int i = 0; i < GRID_CELLS; i++) begin
			cell_stamp[i] = '0;
			cell_live[i] = 1'b0;
		end
	endfunction

	// A gap is the exact difference of two 32-bit times, without wrap-around, and
	// it must be positive and no larger than the useful time window.
	function automatic logic gap_in_window(input logic [31:0] later, input logic [31:0] earlier);
		longint diff;
		diff = longint'({32'd0, later}) - longint'({32'd0, earlier});
		return (diff > 0) && (diff <= longint'({48'd0, cfg_window}));
	endfunction

	// Works out the row results of a scan at the given time and queues them.
	function automatic void predict_scan(input logic [31:0] scan_stamp);
		int cols;
		int rows;
		int len;
		int ir;
		int il;
		logic ok_r;
		logic ok_l;
		logic [31:0] prev_r;
		logic [31:0] prev_l;
		gmcd_pkg::row_result_t res;
		// A chain length of zero switches scanning off altogether.
		if (cfg_len == 0)
			return;
		cols = (cfg_cols > GRID_COLS) ? GRID_COLS : int'(cfg_cols);
		rows = (cfg_rows > GRID_ROWS) ? GRID_ROWS : int'(cfg_rows);
		len = int'(cfg_len);
		for (int r = 0; r < rows; r++) begin
			res = '0;
			res.row = 3'(r);
			res.last = (r + 1 == rows);
			// A chain longer than the active row leaves both masks empty.
			for (int x = 0; x + len <= cols; x++) begin
				ok_r = 1'b1;
				ok_l = 1'b1;
				prev_r = scan_stamp;
				prev_l = scan_stamp;
				// Walk from the newest cell back to the oldest: the rightmost
				// cell for a rightward chain, the leftmost for a leftward one.
				for (int k = 0; k < len; k++) begin
					ir = r * GRID_COLS + (x + len - 1 - k);
					il = r * GRID_COLS + (x + k);
					if (ok_r) begin
						if (!cell_live[ir] || !gap_in_window(prev_r, cell_stamp[ir]))
							ok_r = 1'b0;
						else
							prev_r = cell_stamp[ir];
					end
					if (ok_l) begin
						if (!cell_live[il] || !gap_in_window(prev_l, cell_stamp[il]))
							ok_l = 1'b0;
						else
							prev_l = cell_stamp[il];
					end
				end
				res.right_starts[x] = ok_r;
				res.left_starts[x] = ok_l;
			end
			pending_rows = {pending_rows, res};
		end
	endfunction

	// Updates the predictor for one accepted item.
	function automatic void apply_item(input gmcd_pkg::cmd_item_t it);
		int idx;
		idx = int'(it.cell_row) * GRID_COLS + int'(it.cell_col);
		case (it.cmd)
			gmcd_pkg::CMD_WRITE: begin
				cell_stamp[idx] = it.stamp;
				cell_live[idx] = 1'b1;
			end
			// A clear drops the valid bits and keeps the stored times.
			gmcd_pkg::CMD_CLEAR: begin
				for (int i = 0; i < GRID_CELLS; i++)
					cell_live[i] = 1'b0;
			end
			gmcd_pkg::CMD_SCAN: begin
				predict_scan(it.stamp);
			end
			default: begin
			end
		endcase
	endfunction

	// Every row result is checked against the oldest one still owed. The
	// receiver cannot stall, so each strobe is one accepted result.
	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1) begin
			if (pending_rows.size() == 0) begin
				note_error($sformatf(
					"unexpected row result: row %0d right %02h left %02h last %0d",
					result.row, result.right_starts, result.left_starts, result.last));
			end else begin
				oldest_row = pending_rows.pop_front();
				if (result.row !== oldest_row.row
						|| result.right_starts !== oldest_row.right_starts
						|| result.left_starts !== oldest_row.left_starts
						|| result.last !== oldest_row.last) begin
					note_error($sformatf({"row result mismatch: expected row %0d right %02h ",
						"left %02h last %0d, got row %0d right %02h left %02h last %0d"},
						oldest_row.row, oldest_row.right_starts, oldest_row.left_starts,
						oldest_row.last, result.row, result.right_starts,
						result.left_starts, result.last));
				end
			end
		end
	end

	// Presents one item, after a random gap, and holds it until the block takes
	// it. Start stays high on return so that a following item can come at once.
	task automatic send_item(input gmcd_pkg::cmd_item_t it);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			item <= {8'($urandom), 32'($urandom)};
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_item(it);
		if (it.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic send_cmd(input logic [1:0] op, input int r, input int c,
			input logic [31:0] stamp);
		gmcd_pkg::cmd_item_t it;
		it.cmd = op;
		it.cell_row = 3'(r);
		it.cell_col = 3'(c);
		it.stamp = stamp;
		send_item(it);
	endtask

	// Lowers start and waits until every owed row result has come. With settle
	// set it also waits out the longest scan, so that registers may be written.
	task automatic quiet_until_drained(input bit settle);
		@(negedge clk);
		start <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		if (settle) begin
			repeat (SETTLE_CYCLES)
				@(posedge clk);
			while (busy)
				@(posedge clk);
		end
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			gmcd_pkg::REG_ACTIVE_COLS: cfg_cols = value[3:0];
			gmcd_pkg::REG_ACTIVE_ROWS: cfg_rows = value[3:0];
			gmcd_pkg::REG_CHAIN_LEN:   cfg_len = value[3:0];
			gmcd_pkg::REG_USEFUL_TIME: cfg_window = value;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Writes all four registers; the unused upper bits of the narrow ones get
	// random values, which the block must ignore.
	task automatic configure(input int cols, input int rows, input int len, input int window);
		quiet_until_drained(1'b1);
		set_reg(gmcd_pkg::REG_ACTIVE_COLS, {12'($urandom), 4'(cols)});
		set_reg(gmcd_pkg::REG_ACTIVE_ROWS, {12'($urandom), 4'(rows)});
		set_reg(gmcd_pkg::REG_CHAIN_LEN, {12'($urandom), 4'(len)});
		set_reg(gmcd_pkg::REG_USEFUL_TIME, 16'(window));
	endtask

	// Mostly a gap inside the window; now and then zero, one tick too many, or
	// something wild that may also wrap the 32-bit time.
	function automatic logic [31:0] next_gap();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return 32'd0;
		if (pick == 1)
			return {16'd0, cfg_window} + 32'd1;
		if (pick == 2)
			return $urandom;
		return $urandom_range(1, (cfg_window == 0) ? 1 : int'(cfg_window));
	endfunction

	// Writes a run of adjacent cells in firing order, most often as long as the
	// chain length and inside the active area, so that scans find real chains.
	task automatic lay_chain();
		int n;
		int r;
		int c0;
		int row_span;
		int col_span;
		logic rightward;
		row_span = (cfg_rows == 0 || cfg_rows > GRID_ROWS) ? GRID_ROWS : int'(cfg_rows);
		col_span = (cfg_cols > GRID_COLS) ? GRID_COLS : int'(cfg_cols);
		if ($urandom_range(0, 9) < 8)
			r = $urandom_range(0, row_span - 1);
		else
			r = $urandom_range(0, GRID_ROWS - 1);
		if (cfg_len >= 1 && cfg_len <= GRID_COLS && $urandom_range(0, 3) != 0)
			n = cfg_len;
		else
			n = $urandom_range(1, GRID_COLS);
		if (col_span >= n && $urandom_range(0, 3) != 0)
			c0 = $urandom_range(0, col_span - n);
		else
			c0 = $urandom_range(0, GRID_COLS - n);
		rightward = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0)
			now_ticks = $urandom;
		for (int i = 0; i < n; i++) begin
			now_ticks = now_ticks + next_gap();
			send_cmd(gmcd_pkg::CMD_WRITE, r, rightward ? c0 + i : c0 + n - 1 - i, now_ticks);
		end
	endtask

	// Scans a little after the newest write; the cell fields carry junk.
	task automatic scan_now();
		now_ticks = now_ticks + next_gap();
		send_cmd(gmcd_pkg::CMD_SCAN, $urandom_range(0, 7), $urandom_range(0, 7), now_ticks);
	endtask

	task automatic random_configure();
		int cols;
		int rows;
		int len;
		int window;
		cols = ($urandom_range(0, 99) < 80) ? $urandom_range(2, 8) : $urandom_range(0, 15);
		rows = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(0, 15);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 4);
			7: len = $urandom_range(5, 8);
			8: len = 0;
			default: len = $urandom_range(9, 15);
		endcase
		case ($urandom_range(0, 4))
			0: window = 1;
			1: window = $urandom_range(2, 40);
			2: window = 500;
			3: window = 65535;
			default: window = $urandom_range(0, 65535);
		endcase
		configure(cols, rows, len, window);
	endtask

	// Mostly chains followed by a scan, with stray writes, clears, ignored
	// commands and the odd pause until the block has caught up.
	task automatic random_mix(input int target);
		int pick;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				lay_chain();
				if ($urandom_range(0, 9) < 7)
					scan_now();
			end else if (pick < 65) begin
				send_cmd(gmcd_pkg::CMD_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
					($urandom_range(0, 1) != 0) ? now_ticks - $urandom_range(0, 1000)
					: $urandom);
			end else if (pick < 69) begin
				send_cmd(gmcd_pkg::CMD_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7),
					$urandom);
			end else if (pick < 72) begin
				send_cmd(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
			end else if (pick < 95) begin
				scan_now();
			end else begin
				quiet_until_drained(1'b0);
			end
		end
	endtask

	// An empty grid after reset reports eight rows with both masks clear.
	task automatic test_empty_grid();
		send_cmd(gmcd_pkg::CMD_SCAN, 0, 0, 32'd1000);
	endtask

	// With the reset settings: a rightward chain ending in the last column, a
	// leftward chain starting in the first, and gaps right at the window edge.
	task automatic test_chain_edges();
		send_cmd(gmcd_pkg::CMD_WRITE, 0, 5, 32'd100);
		send_cmd(gmcd_pkg::CMD_WRITE, 0, 6, 32'd200);
		send_cmd(gmcd_pkg::CMD_WRITE, 0, 7, 32'd300);
		send_cmd(gmcd_pkg::CMD_WRITE, 7, 0, 32'd300);
		send_cmd(gmcd_pkg::CMD_WRITE, 7, 1, 32'd200);
		send_cmd(gmcd_pkg::CMD_WRITE, 7, 2, 32'd100);
		send_cmd(gmcd_pkg::CMD_SCAN, 0, 0, 32'd400);
		send_cmd(gmcd_pkg::CMD_WRITE, 3, 0, 32'd1000);
		send_cmd(gmcd_pkg::CMD_WRITE, 3, 1, 32'd1500);
		send_cmd(gmcd_pkg::CMD_WRITE, 3, 2, 32'd2000);
		send_cmd(gmcd_pkg::CMD_SCAN, 7, 7, 32'd2500);
		// One tick past the window breaks the chain.
		send_cmd(gmcd_pkg::CMD_WRITE, 3, 2, 32'd2001);
		send_cmd(gmcd_pkg::CMD_SCAN, 0, 0, 32'd2002);
	endtask

	// Times at the top of the 32-bit range: a chain that just fits, then a scan
	// time that has wrapped to zero and so lies before every cell.
	task automatic test_stamp_extremes();
		send_cmd(gmcd_pkg::CMD_WRITE, 4, 0, 32'hFFFF_FFFC);
		send_cmd(gmcd_pkg::CMD_WRITE, 4, 1, 32'hFFFF_FFFD);
		send_cmd(gmcd_pkg::CMD_WRITE, 4, 2, 32'hFFFF_FFFE);
		send_cmd(gmcd_pkg::CMD_SCAN, 0, 0, 32'hFFFF_FFFF);
		send_cmd(gmcd_pkg::CMD_SCAN, 7, 7, 32'd0);
		send_cmd(gmcd_pkg::CMD_WRITE, 5, 7, 32'd0);
	endtask

	// The ignored command, a clear, and a chain broken by an invalid cell until
	// the missing cell is written again.
	task automatic test_special_commands();
		send_cmd(CMD_UNUSED, 2, 5, 32'hA5A5_5A5A);
		send_cmd(gmcd_pkg::CMD_CLEAR, 5, 2, 32'h5A5A_A5A5);
		send_cmd(gmcd_pkg::CMD_SCAN, 0, 0, 32'd400);
		send_cmd(gmcd_pkg::CMD_WRITE, 0, 5, 32'd100);
		send_cmd(gmcd_pkg::CMD_WRITE, 0, 6, 32'd200);
		send_cmd(gmcd_pkg::CMD_SCAN, 0, 0, 32'd400);
		send_cmd(gmcd_pkg::CMD_WRITE, 0, 7, 32'd300);
		send_cmd(gmcd_pkg::CMD_SCAN, 0, 0, 32'd400);
		now_ticks = 32'd400;
	endtask

	// Register extremes: chains of one and eight cells, the smallest and largest
	// windows, a window of zero, scanning switched off, no active rows, counts
	// that saturate, and chains longer than the active row.
	task automatic test_register_extremes();
		int cols_set [9]   = '{8, 2, 0, 15, 8, 8, 1, 8, 4};
		int rows_set [9]   = '{8, 1, 8, 15, 0, 8, 3, 8, 2};
		int len_set [9]    = '{1, 2, 3, 8, 3, 0, 1, 9, 15};
		int window_set [9] = '{1, 65535, 500, 65535, 500, 500, 10, 500, 0};
		for (int s = 0; s < 9; s++) begin
			configure(cols_set[s], rows_set[s], len_set[s], window_set[s]);
			repeat (3) begin
				lay_chain();
				scan_now();
			end
		end
	endtask

	// Random traffic under three sender gap rates, each with fresh register
	// settings every twenty-five items or so.
	task automatic test_random_traffic();
		int idle_rates [3] = '{31, 67, 0};
		for (int p = 0; p < 3; p++) begin
			sender_idle_pct = idle_rates[p];
			repeat (3) begin
				random_configure();
				random_mix(items_sent + 25);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		now_ticks = 32'd1000;
		reset_predictor();
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_grid();
		test_chain_edges();
		test_stamp_extremes();
		test_special_commands();
		test_register_extremes();
		test_random_traffic();

		// Let every owed row come and the last scan run out before the verdict.
		quiet_until_drained(1'b1);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/gmcd_pkg.sv
design/gmcd_ram.sv
design/gmcd_gap.sv
design/grid_motion_chain_detect_core.sv
sim/testbench.sv
